/* hdl/shi_pkg.sv */
// Shared constants and opcodes for the sparse histogram intersection unit.
`timescale 1ns / 1ps

package shi_pkg;

    // Default geometry of the two entry stores.
    localparam int DEFAULT_MAX_ENTRIES = 1024;
    localparam int DEFAULT_INDEX_BITS  = 20;
    localparam int DEFAULT_VALUE_BITS  = 32;

    // The accumulated sum is signed Q32.16 in 48 bits, already whole bytes.
    localparam int SUM_BITS = 48;

    // Opcodes carried on the input tuser.
    localparam int OPCODE_BITS = 2;
    localparam logic [OPCODE_BITS-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_COMPUTE = 2'd2;

endpackage

/* hdl/sparse_histogram_intersection_unit.sv */
// Top level of the sparse histogram intersection unit: load handling and merge-walk sequencer.
`timescale 1ns / 1ps

// Two sparse vectors A and B are loaded one (index, value) entry per transaction,
// indices ascending, and a compute transaction returns the saturated signed Q32.16
// sum of min(a, b) over matching indices together with a flag that tells whether
// any load since the last compute was dropped because its store was full. Loads
// and the unused opcode produce no result. A compute transaction runs a merge
// walk over both stores with one compare unit and one saturating adder: each
// step reads both stores (ST_READ) and compares the indices (ST_CMP), and a
// matching step also accumulates (ST_ADD); when either store is used up, the
// result is offered from ST_EMIT. Input tready is low during the walk. A result
// waits in an output register, so loads are taken while it is still pending.
// The stores need no clearing after reset.
module sparse_histogram_intersection_unit #(
    parameter int MAX_ENTRIES = shi_pkg::DEFAULT_MAX_ENTRIES,
    parameter int INDEX_BITS  = shi_pkg::DEFAULT_INDEX_BITS,
    parameter int VALUE_BITS  = shi_pkg::DEFAULT_VALUE_BITS,
    parameter int IN_DATA_W   = ((INDEX_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_DATA_W-1:0]             s_tdata,  // entry_index, entry_value, zero pad
    input  logic [shi_pkg::OPCODE_BITS-1:0]  s_tuser,  // opcode
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [shi_pkg::SUM_BITS-1:0]     m_tdata,  // intersection_sum
    output logic [0:0]                       m_tuser   // overflow_flag
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = shi_pkg::SUM_BITS;
    localparam int EXT_W  = SUM_W + 1;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [CNT_W-1:0] a_count_reg, a_count_next;
    logic [CNT_W-1:0] b_count_reg, b_count_next;
    logic             dropped_reg, dropped_next;

    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [VALUE_BITS-1:0] min_reg, min_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic                    out_flag_reg, out_flag_next;

    logic                          s_fire;
    logic [shi_pkg::OPCODE_BITS-1:0] opcode;
    logic [INDEX_BITS-1:0]         entry_index;
    logic signed [VALUE_BITS-1:0]  entry_value;

    logic                         a_wr_en, b_wr_en;
    logic [INDEX_BITS-1:0]        a_rd_index, b_rd_index;
    logic signed [VALUE_BITS-1:0] a_rd_value, b_rd_value;

    logic signed [EXT_W-1:0] add_a, add_b, add_s;
    logic signed [SUM_W-1:0] add_sat;

    // Unpack the input transaction.
    assign opcode      = s_tuser;
    assign entry_index = s_tdata[INDEX_BITS-1:0];
    assign entry_value = s_tdata[INDEX_BITS+VALUE_BITS-1:INDEX_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Loads are written at the current fill position unless the store is full.
    assign a_wr_en = s_fire && (opcode == shi_pkg::OP_LOAD_A) && (a_count_reg != CNT_FULL);
    assign b_wr_en = s_fire && (opcode == shi_pkg::OP_LOAD_B) && (b_count_reg != CNT_FULL);

    shi_store #(
        .DEPTH      (MAX_ENTRIES),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_store_a (
        .clk      (clk),
        .wr_en    (a_wr_en),
        .wr_addr  (a_count_reg[ADDR_W-1:0]),
        .wr_index (entry_index),
        .wr_value (entry_value),
        .rd_addr  (i_reg[ADDR_W-1:0]),
        .rd_index (a_rd_index),
        .rd_value (a_rd_value)
    );

    shi_store #(
        .DEPTH      (MAX_ENTRIES),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_store_b (
        .clk      (clk),
        .wr_en    (b_wr_en),
        .wr_addr  (b_count_reg[ADDR_W-1:0]),
        .wr_index (entry_index),
        .wr_value (entry_value),
        .rd_addr  (j_reg[ADDR_W-1:0]),
        .rd_index (b_rd_index),
        .rd_value (b_rd_value)
    );

    // Saturating accumulator: one guard bit, then clamp to the signed 48-bit range.
    assign add_a = {sum_reg[SUM_W-1], sum_reg};
    assign add_b = {{(EXT_W-VALUE_BITS){min_reg[VALUE_BITS-1]}}, min_reg};
    assign add_s = add_a + add_b;

    always_comb
    begin
        if (add_s[EXT_W-1] != add_s[EXT_W-2])
        begin
            add_sat = add_s[EXT_W-1] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            add_sat = add_s[SUM_W-1:0];
        end
    end

    // Sequencer and load bookkeeping.
    always_comb
    begin
        state_next    = state_reg;
        a_count_next  = a_count_reg;
        b_count_next  = b_count_reg;
        dropped_next  = dropped_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        m_valid_next  = m_valid_reg;
        out_sum_next  = out_sum_reg;
        out_flag_next = out_flag_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (opcode)
                        shi_pkg::OP_LOAD_A:
                        begin
                            if (a_count_reg == CNT_FULL)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                a_count_next = a_count_reg + CNT_ONE;
                            end
                        end
                        shi_pkg::OP_LOAD_B:
                        begin
                            if (b_count_reg == CNT_FULL)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                b_count_next = b_count_reg + CNT_ONE;
                            end
                        end
                        shi_pkg::OP_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            sum_next   = '0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            // The unused opcode is taken and ignored.
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // The stores are reading entries i and j during this cycle.
                if ((i_reg >= a_count_reg) || (j_reg >= b_count_reg))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (a_rd_index == b_rd_index)
                begin
                    min_next   = (a_rd_value < b_rd_value) ? a_rd_value : b_rd_value;
                    i_next     = i_reg + CNT_ONE;
                    j_next     = j_reg + CNT_ONE;
                    state_next = ST_ADD;
                end
                else if (a_rd_index > b_rd_index)
                begin
                    j_next     = j_reg + CNT_ONE;
                    state_next = ST_READ;
                end
                else
                begin
                    i_next     = i_reg + CNT_ONE;
                    state_next = ST_READ;
                end
            end
            ST_ADD:
            begin
                sum_next   = add_sat;
                state_next = ST_READ;
            end
            ST_EMIT:
            begin
                // Hand the result over once the output register is free, then empty the stores.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_sum_next  = sum_reg;
                    out_flag_next = dropped_reg;
                    a_count_next  = '0;
                    b_count_next  = '0;
                    dropped_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            a_count_reg <= '0;
            b_count_reg <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        min_reg      <= min_next;
        out_sum_reg  <= out_sum_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_flag_reg;

    // The walk positions never pass the fill counts, which never pass the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (i_reg <= a_count_reg) || (state_reg == ST_IDLE))
        else $error("store A walk position beyond fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (j_reg <= b_count_reg) || (state_reg == ST_IDLE))
        else $error("store B walk position beyond fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_count_reg <= CNT_FULL) && (b_count_reg <= CNT_FULL))
        else $error("fill count exceeds store depth");

    // A compute transaction starts the walk from a cleared sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (opcode == shi_pkg::OP_COMPUTE)) |=>
            ((state_reg == ST_READ) && (sum_reg == '0) && (i_reg == '0) && (j_reg == '0)))
        else $error("compute did not start a fresh walk");

    // A result appears only at the end of a walk, and then the stores are empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |->
            (($past(state_reg) == ST_EMIT) && (a_count_reg == '0) && (b_count_reg == '0)))
        else $error("result issued outside the end of a walk");

endmodule

/* hdl/shi_store.sv */
// Entry store of one sparse vector: index and value memories with a registered read.
`timescale 1ns / 1ps

module shi_store #(
    parameter int DEPTH      = shi_pkg::DEFAULT_MAX_ENTRIES,
    parameter int INDEX_BITS = shi_pkg::DEFAULT_INDEX_BITS,
    parameter int VALUE_BITS = shi_pkg::DEFAULT_VALUE_BITS,
    parameter int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [INDEX_BITS-1:0]        wr_index,
    input  logic signed [VALUE_BITS-1:0] wr_value,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [INDEX_BITS-1:0]        rd_index,
    output logic signed [VALUE_BITS-1:0] rd_value
);

    logic [INDEX_BITS-1:0]        index_mem [0:DEPTH-1];
    logic signed [VALUE_BITS-1:0] value_mem [0:DEPTH-1];

    // Write port, used by load transactions.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            index_mem[wr_addr] <= wr_index;
            value_mem[wr_addr] <= wr_value;
        end
    end

    // Read port, used by the merge walk; the read data is registered.
    always_ff @(posedge clk)
    begin
        rd_index <= index_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule
